### rtl/rrtq_pkg.sv
// ----------------------------------------------------------------------------
// rrtq_pkg: shared types and constants of the round-robin thread queue
// Queue geometry, operation and status codes, and the control structs that
// travel from the top level to the row of slot cells.
// ----------------------------------------------------------------------------
package rrtq_pkg;

  // Queue geometry.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_WIDTH    = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the item fields on the ports.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QCOUNT_W = 5;

  // Operation codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2
  } op_e;

  // Status codes returned with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Operation broadcast to every cell; enables are qualified by the handshake,
  // and the admit and next enables also by the queue not being full or empty.
  typedef struct packed {
    logic admit_en;
    logic remove_en;
    logic next_en;
    id_t  id;
    id_t  head;
  } cell_ctrl_t;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic occupied;  // index below the entry count
    logic tail_sel;  // index equals the entry count (admit target)
    logic last_sel;  // index equals the entry count minus one
  } cell_pos_t;

endpackage

### rtl/rrtq_if.sv
// ----------------------------------------------------------------------------
// rrtq_req_if / rrtq_rsp_if: request and result channels
// Valid/ready channels; an item moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
interface rrtq_req_if;
  import rrtq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

interface rrtq_rsp_if;
  import rrtq_pkg::*;

  logic                valid;
  logic                ready;
  logic [TID_W-1:0]    chosen_id;
  logic [STATUS_W-1:0] status;
  logic [QCOUNT_W-1:0] queue_count;

  modport source (output valid, output chosen_id, output status, output queue_count,
                  input ready);
  modport sink   (input valid, input chosen_id, input status, input queue_count,
                  output ready);
endinterface

### rtl/round_robin_thread_queue_top.sv
// A result is registered at the clock edge that accepts its request.
// Throughput: one request per cycle while the result side takes results; the
// first-match flag rippling through the row of slot cells sets the cycle time.
// A result waiting in the output register does not block the next request
// unless the result side stalls. Reset empties the queue and drops any
// pending result; slot contents are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
// round_robin_thread_queue_top: bounded round-robin queue of thread IDs
// Admits identifiers at the tail, removes the first match, or returns the
// head and rotates it to the tail, using a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module round_robin_thread_queue_top
  import rrtq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rrtq_req_if.sink   req_i,
  rrtq_rsp_if.source rsp_o
);

  // Handshake and request decode.
  logic       accept;
  op_e        op;
  id_t        req_id;
  cnt_t       count_q, count_d;
  logic       full, empty;
  cell_ctrl_t ctrl;

  id_t        slot   [QUEUE_DEPTH];
  logic       hit    [QUEUE_DEPTH+1];
  cell_pos_t  pos    [QUEUE_DEPTH];

  logic                rsp_valid_q;
  logic [TID_W-1:0]    chosen_q, chosen_d;
  status_e             status_q, status_d;
  logic [QCOUNT_W-1:0] qcount_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.kind);
  assign req_id      = ID_WIDTH'(req_i.thread_id);
  assign full        = (count_q == cnt_t'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);

  // Operation broadcast to the cells.
  assign ctrl.admit_en  = accept && (op == OP_ADMIT) && !full;
  assign ctrl.remove_en = accept && (op == OP_REMOVE);
  assign ctrl.next_en   = accept && (op == OP_NEXT) && !empty;
  assign ctrl.id        = req_id;
  assign ctrl.head      = slot[0];

  // Row of slot cells, head at index zero.
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign pos[i].occupied = cnt_t'(i) < count_q;
    assign pos[i].tail_sel = cnt_t'(i) == count_q;
    assign pos[i].last_sel = cnt_t'(i + 1) == count_q;

    rrtq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .pos_i      (pos[i]),
      .nbr_slot_i ((i == QUEUE_DEPTH - 1) ? slot[i] : slot[(i + 1) % QUEUE_DEPTH]),
      .hit_i      (hit[i]),
      .hit_o      (hit[i+1]),
      .slot_o     (slot[i])
    );
  end

  // Entry count update.
  always_comb begin
    count_d = count_q;
    priority if (ctrl.admit_en) begin
      count_d = count_q + cnt_t'(1);
    end else if (ctrl.remove_en && hit[QUEUE_DEPTH]) begin
      count_d = count_q - cnt_t'(1);
    end else begin
      count_d = count_q;
    end
  end

  // Result fields for the accepted request.
  always_comb begin
    chosen_d = '0;
    status_d = ST_OK;
    unique case (op)
      OP_ADMIT: begin
        if (full) status_d = ST_FULL;
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!hit[QUEUE_DEPTH]) begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_NEXT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          chosen_d = TID_W'(slot[0]);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Control state: entry count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chosen_q <= chosen_d;
      status_q <= status_d;
      qcount_q <= QCOUNT_W'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.chosen_id   = chosen_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.queue_count = qcount_q;

  // Checks on the queue bookkeeping.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_admit_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.admit_en |=> count_q == $past(count_q) + cnt_t'(1))
    else $error("admit did not grow the queue");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == ST_FULL) |-> qcount_q == QCOUNT_W'(QUEUE_DEPTH))
    else $error("full status with room left");

  a_chosen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (chosen_q != '0) |-> status_q == ST_OK)
    else $error("identifier returned with an error status");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == ST_EMPTY) |-> qcount_q == '0)
    else $error("empty status with entries present");

endmodule

### rtl/rrtq_cell.sv
// ----------------------------------------------------------------------------
// rrtq_cell: one slot of the shift-register queue
// Holds one identifier, compares it against the request, passes the
// first-match flag on to the next cell and takes its neighbor's value when
// the queue closes a gap or rotates.
// ----------------------------------------------------------------------------
module rrtq_cell
  import rrtq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  cell_pos_t  pos_i,
  input  id_t        nbr_slot_i,   // slot of the cell one place toward the tail (own slot in the last cell)
  input  logic       hit_i,        // a cell nearer the head already matched
  output logic       hit_o,
  output id_t        slot_o
);

  id_t  slot_q, slot_d;
  logic match;

  // Compare only occupied slots; the flag ripples toward the tail.
  assign match = pos_i.occupied && (slot_q == ctrl_i.id);
  assign hit_o = hit_i || match;

  // Next slot value: rotate, close the gap after a removed entry, or admit.
  always_comb begin
    slot_d = slot_q;
    priority if (ctrl_i.next_en) begin
      slot_d = pos_i.last_sel ? ctrl_i.head : nbr_slot_i;
    end else if (ctrl_i.remove_en && hit_o) begin
      slot_d = nbr_slot_i;
    end else if (ctrl_i.admit_en && pos_i.tail_sel) begin
      slot_d = ctrl_i.id;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule
